// File: src/mexp_pkg.sv
// Shared widths, reset value and unit handshake types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

	localparam int OPERAND_BITS = 31;
	localparam int CNT_W        = $clog2(OPERAND_BITS);
	localparam int WIDE_W       = OPERAND_BITS + 2;

	typedef logic [OPERAND_BITS-1:0] operand_t;
	typedef logic [CNT_W-1:0]        bit_cnt_t;
	typedef logic [WIDE_W-1:0]       wide_t;

	localparam operand_t MODULUS_RESET = OPERAND_BITS'(1000000007);

	typedef struct packed {
		logic     start;
		operand_t multiplicand;
		operand_t multiplier;
		operand_t modulus;
	} mm_req_t;

	typedef struct packed {
		logic     done;
		operand_t product;
	} mm_rsp_t;

endpackage

`default_nettype wire

// File: src/mexp_in_if.sv
// Request channel: valid/ready handshake with request type, base and exponent.
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     req_type;
	operand_t base_value;
	operand_t exponent_value;

	modport source (output valid, output req_type, output base_value, output exponent_value,
		input ready);
	modport sink (input valid, input req_type, input base_value, input exponent_value,
		output ready);
endinterface

`default_nettype wire

// File: src/mexp_out_if.sv
// Result channel: valid/ready handshake with the result value.
`default_nettype none

interface mexp_out_if import mexp_pkg::*; ();
	logic     valid;
	logic     ready;
	operand_t result_value;

	modport source (output valid, output result_value, input ready);
	modport sink (input valid, input result_value, output ready);
endinterface

`default_nettype wire

// File: src/mexp_modmul.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`default_nettype none

module mexp_modmul import mexp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mm_req_t req,
	output mm_rsp_t      rsp
);

	logic     busy_q;
	logic     done_q;
	bit_cnt_t cnt_q;
	operand_t acc_q;
	operand_t a_q;
	operand_t b_q;
	operand_t m_q;

	wide_t sum;
	wide_t m1;
	wide_t m2;
	wide_t red;

	always_comb begin
		m1  = WIDE_W'(m_q);
		m2  = WIDE_W'({m_q, 1'b0});
		sum = WIDE_W'({acc_q, 1'b0}) + (b_q[OPERAND_BITS-1] ? WIDE_W'(a_q) : '0);
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OPERAND_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.multiplicand;
			b_q   <= req.multiplier;
			m_q   <= req.modulus;
		end else if (busy_q) begin
			acc_q <= red[OPERAND_BITS-1:0];
			b_q   <= {b_q[OPERAND_BITS-2:0], 1'b0};
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiplier started while busy");
	a_start_mod: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (req.modulus >= OPERAND_BITS'(2) && req.multiplicand < req.modulus))
		else $error("multiplier started with bad operands");
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q || done_q) |-> acc_q < m_q)
		else $error("accumulator not reduced");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

endmodule

`default_nettype wire

// File: src/modular_exponentiation.sv
// Top level: modular power and inverse by square-and-multiply on one shared modular multiplier.
//
// Each request yields one word: base_value to the power exponent_value mod modulus, or for
// req_type 1 base_value to the power modulus-2 (the inverse for a prime modulus; zero maps to
// zero). A modulus below two goes straight to the closing state and gives zero. All arithmetic
// runs through one bit-serial modular multiplier that forms each product from a load and 31
// bit steps. An item costs one product to reduce the base, one square per exponent bit below
// the highest set bit and one multiply per set bit (bits counted up to the highest set bit),
// plus a pass through the step state per exponent bit and a last one that leads to the closing
// state, which loads the output register. in.ready is high only while the sequencer is idle;
// a finished word waits in the output register while the next request is taken.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mexp_in_if.sink        in,
	mexp_out_if.source     out,
	input  wire logic      cfg_we,
	input  wire operand_t  cfg_wdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SQR  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	operand_t   mod_q;
	operand_t   acc_q;
	operand_t   b_q;
	operand_t   e_q;
	operand_t   res_q;
	logic       inv_q;
	logic       out_valid_q;
	operand_t   out_data_q;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;
	logic    in_fire;
	logic    mod_small;

	assign in.ready  = (state_q == ST_IDLE);
	assign in_fire   = in.valid && in.ready;
	assign mod_small = (mod_q < OPERAND_BITS'(2));

	always_comb begin
		mm_req.start        = 1'b0;
		mm_req.multiplicand = b_q;
		mm_req.multiplier   = b_q;
		mm_req.modulus      = mod_q;
		case (state_q)
			ST_IDLE: begin
				mm_req.start        = in_fire && !mod_small;
				mm_req.multiplicand = OPERAND_BITS'(1);
				mm_req.multiplier   = in.base_value;
			end
			ST_STEP: begin
				mm_req.start = (e_q != '0);
				if (e_q[0]) begin
					mm_req.multiplicand = acc_q;
				end
			end
			ST_MUL: begin
				mm_req.start = mm_rsp.done && (e_q != OPERAND_BITS'(1));
			end
			default: begin
				mm_req.start = 1'b0;
			end
		endcase
	end

	mexp_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mod_q       <= MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (state_q == ST_FIN && (!out_valid_q || out.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= mod_small ? ST_FIN : ST_RED;
					end
				end
				ST_RED: begin
					if (mm_rsp.done) begin
						state_q <= (inv_q && mm_rsp.product == '0) ? ST_FIN : ST_STEP;
					end
				end
				ST_STEP: begin
					if (e_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= e_q[0] ? ST_MUL : ST_SQR;
					end
				end
				ST_MUL: begin
					if (mm_rsp.done) begin
						state_q <= (e_q == OPERAND_BITS'(1)) ? ST_STEP : ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_rsp.done) begin
						state_q <= ST_STEP;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					inv_q <= in.req_type;
					acc_q <= OPERAND_BITS'(1);
					e_q   <= in.req_type ? (mod_q - OPERAND_BITS'(2)) : in.exponent_value;
					res_q <= '0;
				end
			end
			ST_RED: begin
				if (mm_rsp.done) begin
					b_q <= mm_rsp.product;
				end
			end
			ST_STEP: begin
				res_q <= acc_q;
			end
			ST_MUL: begin
				if (mm_rsp.done) begin
					acc_q <= mm_rsp.product;
					if (e_q == OPERAND_BITS'(1)) begin
						e_q <= '0;
					end
				end
			end
			ST_SQR: begin
				if (mm_rsp.done) begin
					b_q <= mm_rsp.product;
					e_q <= {1'b0, e_q[OPERAND_BITS-1:1]};
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out.ready) begin
					out_data_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign out.valid        = out_valid_q;
	assign out.result_value = out_data_q;

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR))
		else $error("product arrived outside a wait state");
	a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out.ready) |=> state_q == ST_FIN)
		else $error("pending word overwritten");
	a_small_mod_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mod_small) |=> state_q == ST_FIN)
		else $error("small modulus not short-circuited");

endmodule

`default_nettype wire

// File: tb/modular_exponentiation_tb.sv
// Testbench for modular_exponentiation: directed and random power and inverse requests checked against a predictor.
`default_nettype none

module modular_exponentiation_tb;
	import mexp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic     req_type;
		operand_t base_value;
		operand_t exponent_value;
	} pow_request_t;

	localparam operand_t OPERAND_MAX = '1;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	operand_t cfg_wdata;

	mexp_in_if  in_ch ();
	mexp_out_if out_ch ();

	modular_exponentiation u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_ch),
		.out       (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	pow_request_t request_queue[$];
	operand_t     awaiting_results[$];
	operand_t     model_modulus = MODULUS_RESET;

	int error_count;
	int words_sent;
	int words_checked;
	int inverse_count;
	int modulus_settings;

	int unsigned send_gap;
	bit          send_quiet;
	int unsigned recv_stall;
	bit          recv_quiet;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic operand_t predict_power(logic inverse, operand_t b, operand_t e,
		operand_t m);
		bit [63:0] acc;
		bit [63:0] sq;
		bit [63:0] mod_w;
		bit [63:0] expo;
		if (m < 2)
			return '0;
		mod_w = 64'(m);
		sq    = 64'(b) % mod_w;
		if (inverse) begin
			if (sq == 0)
				return '0;
			expo = mod_w - 2;
		end else begin
			expo = 64'(e);
		end
		acc = 1;
		for (int i = 0; i < OPERAND_BITS; i++) begin
			if (expo[i])
				acc = (acc * sq) % mod_w;
			sq = (sq * sq) % mod_w;
		end
		return operand_t'(acc);
	endfunction

	task automatic report_mismatch(string what, operand_t got, operand_t want);
		$display("%0t ns: %s: got %0d, wanted %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic add_request(logic inverse, operand_t b, operand_t e);
		pow_request_t r;
		r.req_type       = inverse;
		r.base_value     = b;
		r.exponent_value = e;
		request_queue = {request_queue, r};
	endtask

	function automatic operand_t pick_base(operand_t m);
		bit [63:0] multiple;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return operand_t'(1);
			2: return m - 1;
			3: return m;
			4: begin
				multiple = 64'(m) * $urandom_range(2, 5);
				return (multiple > 64'(OPERAND_MAX)) ? m : operand_t'(multiple);
			end
			5: return OPERAND_MAX;
			default: return operand_t'($urandom);
		endcase
	endfunction

	function automatic operand_t pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return operand_t'(1);
			2: return operand_t'($urandom_range(2, 64));
			3: return OPERAND_MAX;
			default: return operand_t'($urandom) >> $urandom_range(0, OPERAND_BITS - 1);
		endcase
	endfunction

	task automatic write_modulus(operand_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_modulus = value;
		modulus_settings++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || in_ch.valid || awaiting_results.size() != 0);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		pow_request_t next_req;
		if (!arst_n) begin
			in_ch.valid          <= 1'b0;
			in_ch.req_type       <= 1'b0;
			in_ch.base_value     <= '0;
			in_ch.exponent_value <= '0;
			send_gap             <= 0;
			send_quiet           <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				awaiting_results = {awaiting_results, predict_power(in_ch.req_type,
					in_ch.base_value, in_ch.exponent_value, model_modulus)};
				words_sent++;
				if (in_ch.req_type)
					inverse_count++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap != 0) begin
					send_gap    <= send_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					next_req = request_queue.pop_front();
					in_ch.valid          <= 1'b1;
					in_ch.req_type       <= next_req.req_type;
					in_ch.base_value     <= next_req.base_value;
					in_ch.exponent_value <= next_req.exponent_value;
					send_gap             <= send_quiet ? 0 : $urandom_range(0, 11);
					if ($urandom_range(0, 15) == 0)
						send_quiet <= !send_quiet;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		int unsigned draw;
		operand_t    want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall   <= 0;
			recv_quiet   <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (awaiting_results.size() == 0) begin
					report_mismatch("word with nothing pending", out_ch.result_value, '0);
				end else begin
					want = awaiting_results.pop_front();
					if (out_ch.result_value !== want)
						report_mismatch("result_value", out_ch.result_value, want);
					words_checked++;
				end
				draw = recv_quiet ? 0 : $urandom_range(0, 11);
				if ($urandom_range(0, 15) == 0)
					recv_quiet <= !recv_quiet;
				recv_stall   <= draw;
				out_ch.ready <= (draw == 0);
			end else if (recv_stall != 0) begin
				recv_stall   <= recv_stall - 1;
				out_ch.ready <= (recv_stall == 1);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		operand_t m;
		operand_t moduli[12];
		int       counts[12];

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		in_ch.valid          = 1'b0;
		in_ch.req_type       = 1'b0;
		in_ch.base_value     = '0;
		in_ch.exponent_value = '0;
		out_ch.ready         = 1'b0;

		moduli = '{'0, operand_t'(1), operand_t'(2), operand_t'(3), operand_t'(97), OPERAND_MAX,
			operand_t'(1000000), OPERAND_MAX - 1, MODULUS_RESET,
			operand_t'($urandom_range(2, 32'h7fff_ffff)),
			operand_t'($urandom_range(2, 32'h7fff_ffff)),
			operand_t'($urandom_range(2, 1000))};
		counts = '{12, 12, 20, 25, 30, 100, 40, 40, 100, 60, 60, 40};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset modulus
		m = MODULUS_RESET;
		add_request(1'b0, '0, '0);
		add_request(1'b0, '0, operand_t'(1));
		add_request(1'b0, OPERAND_MAX, '0);
		add_request(1'b0, OPERAND_MAX, OPERAND_MAX);
		add_request(1'b0, operand_t'(1), OPERAND_MAX);
		add_request(1'b0, operand_t'(2), operand_t'(30));
		add_request(1'b0, operand_t'(3), operand_t'(1) << (OPERAND_BITS - 1));
		add_request(1'b0, m - 1, operand_t'(2));
		add_request(1'b0, m, operand_t'(5));
		add_request(1'b0, m + 1, OPERAND_MAX);
		add_request(1'b0, operand_t'(2), m - 1);
		add_request(1'b1, '0, OPERAND_MAX);
		add_request(1'b1, m, '0);
		add_request(1'b1, m * 2, operand_t'(7));
		add_request(1'b1, operand_t'(1), '0);
		add_request(1'b1, operand_t'(2), operand_t'(12345));
		add_request(1'b1, OPERAND_MAX, OPERAND_MAX);
		add_request(1'b1, m - 1, '0);
		add_request(1'b1, m + 1, operand_t'(1));
		wait_drained();

		foreach (moduli[p]) begin
			write_modulus(moduli[p]);
			for (int k = 0; k < counts[p]; k++)
				add_request(logic'($urandom_range(0, 3) == 0), pick_base(model_modulus),
					pick_exponent());
			wait_drained();
		end

		repeat (100) @(posedge clk);
		$display("Checked %0d of %0d words (%0d inverse requests) over %0d modulus settings.",
			words_checked, words_sent, inverse_count, modulus_settings + 1);
		$display("Moduli included zero, one, two, 2^31-1 and composite values.");
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("Timed out with %0d words still outstanding.", awaiting_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: modular_exponentiation.f
src/mexp_pkg.sv
src/mexp_in_if.sv
src/mexp_out_if.sv
src/mexp_modmul.sv
src/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
